### hw/rtl/ray_sphere_intersection_assert.svh
// Assertion macros used by the checker module.
`ifndef RAY_SPHERE_INTERSECTION_ASSERT_SVH
`define RAY_SPHERE_INTERSECTION_ASSERT_SVH

// Same-cycle implication, off during reset.
`define RSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define RSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Holds while reset is asserted.
`define RSI_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk_i) !rst_ni |-> (cons)) else $error(msg);

`endif

### hw/rtl/rsi_pkg.sv
package rsi_pkg;

  localparam int AXES     = 3;
  localparam int SQ1_RW   = 52;
  localparam int SQ2_RW   = 34;
  localparam int DIV_NW   = 50;
  localparam int DIV_QW   = 16;
  localparam int NORM_ONE = 16384;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [30:0] radius;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } res_t;

endpackage

### hw/rtl/rsi_stream_if.sv
interface rsi_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/ray_sphere_intersection.sv
// Throughput: one request per cycle; the 52-cell and 34-cell square root
// chains and the 16-cell divider chain are fully pipelined.
// The whole pipeline stalls while the output register is full and not taken.
// Reset: asynchronous, active low; clears all valid bits, payload is not reset.
module ray_sphere_intersection (
  input logic          clk_i,
  input logic          rst_ni,
  rsi_stream_if.sink   req_i,
  rsi_stream_if.source res_o
);
  localparam int AX = rsi_pkg::AXES;

  typedef struct packed {
    logic [AX-1:0][31:0] o;
    logic [AX-1:0][15:0] d;
    logic [AX-1:0][31:0] c;
  } geo_t;

  typedef struct packed {
    logic        pos;
    logic [50:0] b;
    geo_t        geo;
  } sq1_pay_t;

  typedef struct packed {
    logic                hit;
    logic [AX-1:0][31:0] p;
    logic [AX-1:0]       nneg;
    logic [AX-1:0][32:0] nabs;
  } sq2_pay_t;

  typedef struct packed {
    logic                hit;
    logic [AX-1:0][31:0] p;
    logic [AX-1:0]       nneg;
    logic                lenz;
  } div_pay_t;

  localparam int Sq1Pw = $bits(sq1_pay_t);
  localparam int Sq2Pw = $bits(sq2_pay_t);
  localparam int DivPw = $bits(div_pay_t);

  logic          adv;
  logic          res_valid_q;
  rsi_pkg::res_t res_q;
  rsi_pkg::res_t res_d;

  assign adv           = !res_valid_q || res_o.ready;
  assign req_i.ready   = adv;
  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  geo_t in_geo;
  always_comb begin
    in_geo.o[0] = req_i.payload.origin_x;
    in_geo.o[1] = req_i.payload.origin_y;
    in_geo.o[2] = req_i.payload.origin_z;
    in_geo.d[0] = req_i.payload.dir_x;
    in_geo.d[1] = req_i.payload.dir_y;
    in_geo.d[2] = req_i.payload.dir_z;
    in_geo.c[0] = req_i.payload.center_x;
    in_geo.c[1] = req_i.payload.center_y;
    in_geo.c[2] = req_i.payload.center_z;
  end

  // front stages
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  geo_t s1_geo_q, s2_geo_q, s3_geo_q, s4_geo_q, s5_geo_q;
  logic signed [32:0]  s1_dv_q [AX];
  logic        [30:0]  s1_r_q;
  logic signed [48:0]  s2_pb_q [AX];
  logic        [65:0]  s2_sq_q [AX];
  logic        [61:0]  s2_rr_q;
  logic signed [50:0]  s3_b_q;
  logic signed [68:0]  s3_e_q;
  logic        [49:0]  s4_hh_q;
  logic        [50:0]  s4_hl_q;
  logic        [51:0]  s4_ll_q;
  logic signed [68:0]  s4_e_q;
  logic signed [50:0]  s4_b_q;
  logic signed [103:0] s5_disc_q;
  logic signed [50:0]  s5_b_q;

  logic signed [50:0]  b_sum;
  logic signed [68:0]  e_dif;
  logic        [50:0]  b_mag;
  logic        [24:0]  b_hi;
  logic        [25:0]  b_lo;
  logic        [101:0] b_sq;
  logic signed [103:0] e_ext;
  logic signed [103:0] disc;

  always_comb begin
    b_sum = s2_pb_q[0] + s2_pb_q[1] + s2_pb_q[2];
    e_dif = $signed({3'b000, s2_sq_q[0]}) + $signed({3'b000, s2_sq_q[1]})
          + $signed({3'b000, s2_sq_q[2]}) - $signed({7'b0000000, s2_rr_q});
    b_mag = s3_b_q[50] ? 51'(-s3_b_q) : 51'(s3_b_q);
    b_hi  = b_mag[50:26];
    b_lo  = b_mag[25:0];
    b_sq  = {s4_hh_q, 52'd0} + {24'd0, s4_hl_q, 27'd0} + {50'd0, s4_ll_q};
    e_ext = s4_e_q;
    disc  = $signed({2'b00, b_sq}) - (e_ext <<< 28);
  end

  // middle stages
  logic s7_v_q, s8_v_q, s9_v_q, s10_v_q;
  logic s7_hit_q, s8_hit_q, s9_hit_q, s10_hit_q;
  geo_t s7_geo_q;
  logic signed [42:0] s7_ph_q [AX];
  logic signed [42:0] s7_pl_q [AX];
  logic        [31:0] s8_p_q  [AX];
  logic        [31:0] s8_c_q  [AX];
  logic signed [32:0] s9_n_q  [AX];
  logic        [31:0] s9_p_q  [AX];
  logic        [65:0] s10_sq_q [AX];
  logic        [32:0] s10_nabs_q [AX];
  logic        [AX-1:0] s10_nneg_q;
  logic        [31:0] s10_p_q [AX];

  // first square root chain
  logic                 sq1_v    [rsi_pkg::SQ1_RW];
  logic [2*rsi_pkg::SQ1_RW-1:0] sq1_rem [rsi_pkg::SQ1_RW];
  logic [rsi_pkg::SQ1_RW-1:0]   sq1_root [rsi_pkg::SQ1_RW];
  logic [Sq1Pw-1:0]     sq1_pay  [rsi_pkg::SQ1_RW];
  logic                 sq1_v_w;
  logic [rsi_pkg::SQ1_RW-1:0]   sq1_root_w;
  logic [Sq1Pw-1:0]     sq1_pay_w;
  sq1_pay_t             sq1_in_pay;
  sq1_pay_t             sq1_out;
  logic                 disc_pos;

  assign disc_pos = !s5_disc_q[103] && (s5_disc_q != '0);
  always_comb begin
    sq1_in_pay.pos = disc_pos;
    sq1_in_pay.b   = s5_b_q;
    sq1_in_pay.geo = s5_geo_q;
  end
  assign sq1_v[0]    = s5_v_q;
  assign sq1_rem[0]  = disc_pos ? s5_disc_q : '0;
  assign sq1_root[0] = '0;
  assign sq1_pay[0]  = sq1_in_pay;

  for (genvar k = 0; k < rsi_pkg::SQ1_RW; k++) begin : g_sq1
    if (k < rsi_pkg::SQ1_RW - 1) begin : g_mid
      rsi_sqrt_cell #(.RW(rsi_pkg::SQ1_RW), .BIT(rsi_pkg::SQ1_RW - 1 - k), .PW(Sq1Pw)) u_cell (
        .clk_i, .rst_ni, .en_i(adv),
        .valid_i(sq1_v[k]), .rem_i(sq1_rem[k]), .root_i(sq1_root[k]), .pay_i(sq1_pay[k]),
        .valid_o(sq1_v[k+1]), .rem_o(sq1_rem[k+1]), .root_o(sq1_root[k+1]),
        .pay_o(sq1_pay[k+1])
      );
    end else begin : g_last
      rsi_sqrt_cell #(.RW(rsi_pkg::SQ1_RW), .BIT(0), .PW(Sq1Pw)) u_cell (
        .clk_i, .rst_ni, .en_i(adv),
        .valid_i(sq1_v[k]), .rem_i(sq1_rem[k]), .root_i(sq1_root[k]), .pay_i(sq1_pay[k]),
        .valid_o(sq1_v_w), .rem_o(), .root_o(sq1_root_w), .pay_o(sq1_pay_w)
      );
    end
  end

  assign sq1_out = sq1_pay_w;

  logic signed [53:0] t2;
  logic               hit7;
  logic        [51:0] t2u;
  always_comb begin
    t2   = -$signed(sq1_out.b) - $signed({2'b00, sq1_root_w});
    hit7 = sq1_out.pos && !t2[53] && (t2 != '0);
    t2u  = hit7 ? t2[51:0] : '0;
  end

  logic signed [69:0] prod [AX];
  logic signed [43:0] qsum [AX];
  logic        [31:0] psat [AX];
  always_comb begin
    for (int i = 0; i < AX; i++) begin
      prod[i] = s7_ph_q[i];
      prod[i] = (prod[i] <<< 26) + s7_pl_q[i];
      qsum[i] = 44'((prod[i] >>> 28) + $signed(s7_geo_q.o[i]));
      if (!qsum[i][43] && (|qsum[i][42:31])) begin
        psat[i] = 32'h7fff_ffff;
      end else if (qsum[i][43] && !(&qsum[i][42:31])) begin
        psat[i] = 32'h8000_0000;
      end else begin
        psat[i] = qsum[i][31:0];
      end
    end
  end

  // second square root chain
  logic                 sq2_v    [rsi_pkg::SQ2_RW];
  logic [2*rsi_pkg::SQ2_RW-1:0] sq2_rem [rsi_pkg::SQ2_RW];
  logic [rsi_pkg::SQ2_RW-1:0]   sq2_root [rsi_pkg::SQ2_RW];
  logic [Sq2Pw-1:0]     sq2_pay  [rsi_pkg::SQ2_RW];
  logic                 sq2_v_w;
  logic [rsi_pkg::SQ2_RW-1:0]   sq2_root_w;
  logic [Sq2Pw-1:0]     sq2_pay_w;
  sq2_pay_t             sq2_in_pay;
  sq2_pay_t             sq2_out;

  always_comb begin
    sq2_in_pay.hit  = s10_hit_q;
    sq2_in_pay.nneg = s10_nneg_q;
    for (int i = 0; i < AX; i++) begin
      sq2_in_pay.p[i]    = s10_p_q[i];
      sq2_in_pay.nabs[i] = s10_nabs_q[i];
    end
  end
  assign sq2_v[0]    = s10_v_q;
  assign sq2_rem[0]  = {2'b00, s10_sq_q[0]} + {2'b00, s10_sq_q[1]} + {2'b00, s10_sq_q[2]};
  assign sq2_root[0] = '0;
  assign sq2_pay[0]  = sq2_in_pay;

  for (genvar k = 0; k < rsi_pkg::SQ2_RW; k++) begin : g_sq2
    if (k < rsi_pkg::SQ2_RW - 1) begin : g_mid
      rsi_sqrt_cell #(.RW(rsi_pkg::SQ2_RW), .BIT(rsi_pkg::SQ2_RW - 1 - k), .PW(Sq2Pw)) u_cell (
        .clk_i, .rst_ni, .en_i(adv),
        .valid_i(sq2_v[k]), .rem_i(sq2_rem[k]), .root_i(sq2_root[k]), .pay_i(sq2_pay[k]),
        .valid_o(sq2_v[k+1]), .rem_o(sq2_rem[k+1]), .root_o(sq2_root[k+1]),
        .pay_o(sq2_pay[k+1])
      );
    end else begin : g_last
      rsi_sqrt_cell #(.RW(rsi_pkg::SQ2_RW), .BIT(0), .PW(Sq2Pw)) u_cell (
        .clk_i, .rst_ni, .en_i(adv),
        .valid_i(sq2_v[k]), .rem_i(sq2_rem[k]), .root_i(sq2_root[k]), .pay_i(sq2_pay[k]),
        .valid_o(sq2_v_w), .rem_o(), .root_o(sq2_root_w), .pay_o(sq2_pay_w)
      );
    end
  end

  assign sq2_out = sq2_pay_w;

  // divider chain, one quotient bit per cell for all three axes
  logic                                  dv_v   [rsi_pkg::DIV_QW];
  logic [AX-1:0][rsi_pkg::DIV_NW-1:0]    dv_rem [rsi_pkg::DIV_QW];
  logic [AX-1:0][rsi_pkg::DIV_QW-1:0]    dv_quo [rsi_pkg::DIV_QW];
  logic [rsi_pkg::SQ2_RW-1:0]            dv_div [rsi_pkg::DIV_QW];
  logic [DivPw-1:0]                      dv_pay [rsi_pkg::DIV_QW];
  logic                                  dv_v_w;
  logic [AX-1:0][rsi_pkg::DIV_QW-1:0]    dv_quo_w;
  logic [DivPw-1:0]                      dv_pay_w;
  div_pay_t                              dv_in_pay;
  div_pay_t                              dv_out;
  logic [AX-1:0][rsi_pkg::DIV_NW-1:0]    dv_in_rem;

  always_comb begin
    dv_in_pay.hit  = sq2_out.hit;
    dv_in_pay.p    = sq2_out.p;
    dv_in_pay.nneg = sq2_out.nneg;
    dv_in_pay.lenz = (sq2_root_w == '0);
    for (int i = 0; i < AX; i++) begin
      dv_in_rem[i] = {3'b000, sq2_out.nabs[i], 14'd0};
    end
  end
  assign dv_v[0]   = sq2_v_w;
  assign dv_rem[0] = dv_in_rem;
  assign dv_quo[0] = '0;
  assign dv_div[0] = sq2_root_w;
  assign dv_pay[0] = dv_in_pay;

  for (genvar k = 0; k < rsi_pkg::DIV_QW; k++) begin : g_div
    if (k < rsi_pkg::DIV_QW - 1) begin : g_mid
      rsi_div_cell #(
        .NW(rsi_pkg::DIV_NW), .DW(rsi_pkg::SQ2_RW), .QW(rsi_pkg::DIV_QW),
        .BIT(rsi_pkg::DIV_QW - 1 - k), .PW(DivPw)
      ) u_cell (
        .clk_i, .rst_ni, .en_i(adv),
        .valid_i(dv_v[k]), .rem_i(dv_rem[k]), .quo_i(dv_quo[k]), .div_i(dv_div[k]),
        .pay_i(dv_pay[k]),
        .valid_o(dv_v[k+1]), .rem_o(dv_rem[k+1]), .quo_o(dv_quo[k+1]), .div_o(dv_div[k+1]),
        .pay_o(dv_pay[k+1])
      );
    end else begin : g_last
      rsi_div_cell #(
        .NW(rsi_pkg::DIV_NW), .DW(rsi_pkg::SQ2_RW), .QW(rsi_pkg::DIV_QW),
        .BIT(0), .PW(DivPw)
      ) u_cell (
        .clk_i, .rst_ni, .en_i(adv),
        .valid_i(dv_v[k]), .rem_i(dv_rem[k]), .quo_i(dv_quo[k]), .div_i(dv_div[k]),
        .pay_i(dv_pay[k]),
        .valid_o(dv_v_w), .rem_o(), .quo_o(dv_quo_w), .div_o(), .pay_o(dv_pay_w)
      );
    end
  end

  assign dv_out = dv_pay_w;

  logic [15:0] qc [AX];
  logic [15:0] nv [AX];
  logic        nrm_ok;
  always_comb begin
    nrm_ok = dv_out.hit && !dv_out.lenz;
    for (int i = 0; i < AX; i++) begin
      qc[i] = (dv_quo_w[i] > 16'(rsi_pkg::NORM_ONE)) ? 16'(rsi_pkg::NORM_ONE) : dv_quo_w[i];
      nv[i] = !nrm_ok ? 16'd0 : (dv_out.nneg[i] ? 16'd0 - qc[i] : qc[i]);
    end
    res_d.hit      = dv_out.hit;
    res_d.point_x  = dv_out.hit ? dv_out.p[0] : '0;
    res_d.point_y  = dv_out.hit ? dv_out.p[1] : '0;
    res_d.point_z  = dv_out.hit ? dv_out.p[2] : '0;
    res_d.normal_x = nv[0];
    res_d.normal_y = nv[1];
    res_d.normal_z = nv[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s7_v_q      <= 1'b0;
      s8_v_q      <= 1'b0;
      s9_v_q      <= 1'b0;
      s10_v_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= req_i.valid;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q;
      s7_v_q      <= sq1_v_w;
      s8_v_q      <= s7_v_q;
      s9_v_q      <= s8_v_q;
      s10_v_q     <= s9_v_q;
      res_valid_q <= dv_v_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_geo_q <= in_geo;
      s1_r_q   <= req_i.payload.radius;
      for (int i = 0; i < AX; i++) begin
        s1_dv_q[i] <= $signed({in_geo.o[i][31], in_geo.o[i]})
                    - $signed({in_geo.c[i][31], in_geo.c[i]});
      end

      s2_geo_q <= s1_geo_q;
      s2_rr_q  <= s1_r_q * s1_r_q;
      for (int i = 0; i < AX; i++) begin
        s2_pb_q[i] <= $signed(s1_geo_q.d[i]) * s1_dv_q[i];
        s2_sq_q[i] <= s1_dv_q[i] * s1_dv_q[i];
      end

      s3_geo_q <= s2_geo_q;
      s3_b_q   <= b_sum;
      s3_e_q   <= e_dif;

      s4_geo_q <= s3_geo_q;
      s4_b_q   <= s3_b_q;
      s4_e_q   <= s3_e_q;
      s4_hh_q  <= b_hi * b_hi;
      s4_hl_q  <= b_hi * b_lo;
      s4_ll_q  <= b_lo * b_lo;

      s5_geo_q  <= s4_geo_q;
      s5_b_q    <= s4_b_q;
      s5_disc_q <= disc;

      s7_geo_q <= sq1_out.geo;
      s7_hit_q <= hit7;
      for (int i = 0; i < AX; i++) begin
        s7_ph_q[i] <= $signed(sq1_out.geo.d[i]) * $signed({1'b0, t2u[51:26]});
        s7_pl_q[i] <= $signed(sq1_out.geo.d[i]) * $signed({1'b0, t2u[25:0]});
      end

      s8_hit_q <= s7_hit_q;
      for (int i = 0; i < AX; i++) begin
        s8_p_q[i] <= psat[i];
        s8_c_q[i] <= s7_geo_q.c[i];
      end

      s9_hit_q <= s8_hit_q;
      for (int i = 0; i < AX; i++) begin
        s9_p_q[i] <= s8_p_q[i];
        s9_n_q[i] <= $signed({s8_p_q[i][31], s8_p_q[i]}) - $signed({s8_c_q[i][31], s8_c_q[i]});
      end

      s10_hit_q <= s9_hit_q;
      for (int i = 0; i < AX; i++) begin
        s10_p_q[i]    <= s9_p_q[i];
        s10_sq_q[i]   <= s9_n_q[i] * s9_n_q[i];
        s10_nabs_q[i] <= s9_n_q[i][32] ? 33'(-s9_n_q[i]) : 33'(s9_n_q[i]);
        s10_nneg_q[i] <= s9_n_q[i][32];
      end

      res_q <= res_d;
    end
  end
endmodule

### hw/rtl/rsi_sqrt_cell.sv
module rsi_sqrt_cell #(
  parameter int RW  = 52,
  parameter int BIT = 0,
  parameter int PW  = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [PW-1:0]   pay_i,
  output logic            valid_o,
  output logic [2*RW-1:0] rem_o,
  output logic [RW-1:0]   root_o,
  output logic [PW-1:0]   pay_o
);
  localparam int VW = 2 * RW;

  logic [VW-1:0] trial;
  logic          ge;
  logic          valid_q;
  logic [VW-1:0] rem_q;
  logic [RW-1:0] root_q;
  logic [PW-1:0] pay_q;

  // (root + 2^BIT)^2 - root^2
  assign trial = (VW'(root_i) << (BIT + 1)) | (VW'(1) << (2 * BIT));
  assign ge    = rem_i >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= ge ? rem_i - trial : rem_i;
      root_q <= ge ? (root_i | (RW'(1) << BIT)) : root_i;
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pay_o   = pay_q;
endmodule

### hw/rtl/rsi_div_cell.sv
module rsi_div_cell #(
  parameter int NW  = 50,
  parameter int DW  = 34,
  parameter int QW  = 16,
  parameter int BIT = 0,
  parameter int PW  = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [rsi_pkg::AXES-1:0][NW-1:0] rem_i,
  input  logic [rsi_pkg::AXES-1:0][QW-1:0] quo_i,
  input  logic [DW-1:0]                    div_i,
  input  logic [PW-1:0]                    pay_i,
  output logic                             valid_o,
  output logic [rsi_pkg::AXES-1:0][NW-1:0] rem_o,
  output logic [rsi_pkg::AXES-1:0][QW-1:0] quo_o,
  output logic [DW-1:0]                    div_o,
  output logic [PW-1:0]                    pay_o
);
  logic [NW-1:0]                    shifted;
  logic [rsi_pkg::AXES-1:0]         ge;
  logic                             valid_q;
  logic [rsi_pkg::AXES-1:0][NW-1:0] rem_q;
  logic [rsi_pkg::AXES-1:0][QW-1:0] quo_q;
  logic [DW-1:0]                    div_q;
  logic [PW-1:0]                    pay_q;

  assign shifted = NW'(div_i) << BIT;

  always_comb begin
    for (int l = 0; l < rsi_pkg::AXES; l++) begin
      ge[l] = rem_i[l] >= shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < rsi_pkg::AXES; l++) begin
        rem_q[l] <= ge[l] ? rem_i[l] - shifted : rem_i[l];
        quo_q[l] <= ge[l] ? (quo_i[l] | (QW'(1) << BIT)) : quo_i[l];
      end
      div_q <= div_i;
      pay_q <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign div_o   = div_q;
  assign pay_o   = pay_q;
endmodule

### hw/rtl/rsi_checker.sv
module rsi_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_ready_i,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input rsi_pkg::res_t res_payload_i
);
  `include "ray_sphere_intersection_assert.svh"

  `RSI_ASSERT_RST(a_rst_idle, !res_valid_i, "result valid during reset")
  `RSI_ASSERT_IMP(a_ready, 1'b1, req_ready_i == (!res_valid_i || res_ready_i), "ready mismatch")
  `RSI_ASSERT_NXT(a_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_payload_i), "stalled result changed")
  `RSI_ASSERT_IMP(a_miss_zero, res_valid_i && !res_payload_i.hit, res_payload_i.point_x == 0 && res_payload_i.point_y == 0 && res_payload_i.point_z == 0 && res_payload_i.normal_x == 0 && res_payload_i.normal_y == 0 && res_payload_i.normal_z == 0, "miss with nonzero fields")
  `RSI_ASSERT_IMP(a_norm_range, res_valid_i, res_payload_i.normal_x <= rsi_pkg::NORM_ONE && res_payload_i.normal_x >= -rsi_pkg::NORM_ONE && res_payload_i.normal_y <= rsi_pkg::NORM_ONE && res_payload_i.normal_y >= -rsi_pkg::NORM_ONE && res_payload_i.normal_z <= rsi_pkg::NORM_ONE && res_payload_i.normal_z >= -rsi_pkg::NORM_ONE, "normal out of range")
endmodule

bind ray_sphere_intersection rsi_checker u_rsi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_ready_i   (req_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_payload_i (res_o.payload)
);
